// ----- hdl/ptw16_pkg.sv -----
package ptw16_pkg;

  localparam int unsigned PHYS_BITS = 40;
  localparam int unsigned ADDR_BITS = 41;   // entry address width
  localparam int unsigned GRAN_BITS = 14;
  localparam int unsigned IDX_BITS  = 11;
  localparam int unsigned XN_POS    = 53;
  localparam int unsigned AP_POS    = 6;

  // translation control field values
  localparam logic [2:0] IPS_40     = 3'd2;
  localparam logic [1:0] GRAN_16K   = 2'd1;
  localparam logic [1:0] TYPE_TABLE = 2'd3;
  localparam logic [5:0] TSZ_MIN    = 6'd17;
  localparam logic [5:0] TSZ_MAX    = 6'd27;

  // configuration register indexes
  localparam logic [1:0] CFG_TCR       = 2'd0;
  localparam logic [1:0] CFG_LOW_BASE  = 2'd1;
  localparam logic [1:0] CFG_HIGH_BASE = 2'd2;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FAULT = 2'd3
  } kind_t;

  localparam logic [3:0] FLT_NONE    = 4'd0;
  localparam logic [3:0] FLT_IPS     = 4'd1;
  localparam logic [3:0] FLT_UPPER   = 4'd2;
  localparam logic [3:0] FLT_GRANULE = 4'd3;
  localparam logic [3:0] FLT_SIZE    = 4'd4;
  localparam logic [3:0] FLT_L1_ZERO = 4'd5;
  localparam logic [3:0] FLT_L1_TYPE = 4'd6;
  localparam logic [3:0] FLT_L2_ZERO = 4'd7;
  localparam logic [3:0] FLT_L2_TYPE = 4'd8;
  localparam logic [3:0] FLT_L3_ZERO = 4'd9;
  localparam logic [3:0] FLT_L3_TYPE = 4'd10;

  typedef struct packed {
    logic [63:0]          tcr;
    logic [PHYS_BITS-1:0] low_base;
    logic [PHYS_BITS-1:0] high_base;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [63:0]          write_data;
    logic [PHYS_BITS-1:0] phys_addr;
    logic [3:0]           fault_code;
    logic                 flush_tlb;
    logic                 last;
  } result_t;

  // up to two results handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- hdl/page_table_walker_16k.sv -----
// Three-level stage-1 table walker, 16 KB granule, 40-bit output size.
//
// Input channel (in_*): one item is either a translate request (in_cmd = 0,
// in_virt_addr, in_make_exec) or a table entry word returned from memory
// (in_cmd = 1, in_read_data). An entry word that arrives with no walk open
// is dropped. A request while a walk is open abandons that walk.
// Result channel (out_*): read requests, entry write-backs, finished
// translations and faults; out_last marks the final result of an item.
// Only a level-3 entry with make_exec set gives two results (write, done).
// Config port: cfg_we writes cfg_data to register cfg_index (0 translation
// control, 1 low table base, 2 high table base); write only while idle.
//
// Path: an item accepted into the input register feeds the walk logic, which
// pushes its results into a four-entry result queue whose head drives out_*.
// Throughput: one item per cycle, limited by the output side: an item only
// leaves the input register when the queue has room for two results. When
// out_stall holds, the queue fills and in_stall rises after at most four more
// items. Reset (rst_n low, synchronous) clears the walk, the queue and the
// config registers; no results pending.
module page_table_walker_16k (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [63:0] in_virt_addr,
  input  logic        in_make_exec,
  input  logic [63:0] in_read_data,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [40:0] out_mem_addr,
  output logic [63:0] out_write_data,
  output logic [39:0] out_phys_addr,
  output logic [3:0]  out_fault_code,
  output logic        out_flush_tlb,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  ptw16_pkg::cfg_t    cfg_r;
  ptw16_pkg::push_t   push;
  ptw16_pkg::result_t head;

  // input register
  logic        hold_r;
  logic        cmd_r;
  logic [63:0] va_r;
  logic        exec_r;
  logic [63:0] rdata_r;

  logic room;
  logic proc;

  assign proc     = hold_r && room;
  assign in_stall = hold_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (!in_stall) begin
      hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r   <= in_cmd;
      va_r    <= in_virt_addr;
      exec_r  <= in_make_exec;
      rdata_r <= in_read_data;
    end
  end

  // config registers; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptw16_pkg::CFG_TCR:       cfg_r.tcr       <= cfg_data;
        ptw16_pkg::CFG_LOW_BASE:  cfg_r.low_base  <= cfg_data[39:0];
        ptw16_pkg::CFG_HIGH_BASE: cfg_r.high_base <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  ptw16_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .cmd       (cmd_r),
    .va        (va_r),
    .make_exec (exec_r),
    .rdata     (rdata_r),
    .cfg       (cfg_r),
    .push      (push)
  );

  ptw16_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_kind       = 2'(head.kind);
  assign out_mem_addr   = head.mem_addr;
  assign out_write_data = head.write_data;
  assign out_phys_addr  = head.phys_addr;
  assign out_fault_code = head.fault_code;
  assign out_flush_tlb  = head.flush_tlb;
  assign out_last       = head.last;

endmodule

// ----- hdl/ptw16_walk.sv -----
module ptw16_walk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  logic              cmd,
  input  logic [63:0]       va,
  input  logic              make_exec,
  input  logic [63:0]       rdata,
  input  ptw16_pkg::cfg_t   cfg,
  output ptw16_pkg::push_t  push
);

  typedef enum logic [1:0] {PH_IDLE, PH_L1, PH_L2, PH_L3} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [35:0] saved_low_r, saved_low_nxt;
  logic        exec_r, exec_nxt;
  logic [40:0] final_addr_r, final_addr_nxt;

  logic        sel_hi;
  logic [5:0]  tsz;
  logic [1:0]  gran;
  logic [63:0] top_mask;
  logic        top_ok;
  logic        tsz_ok;
  logic [39:0] base;
  logic [3:0]  idx_shift;
  logic [10:0] l1_idx;
  logic [40:0] l1_addr;
  logic [10:0] nxt_idx;
  logic [40:0] nxt_addr;
  logic [63:0] wdata;
  logic [39:0] pa;
  logic [3:0]  code_zero, code_type;

  function automatic ptw16_pkg::result_t mk(ptw16_pkg::kind_t k, logic [40:0] a,
                                            logic [63:0] w, logic [39:0] p,
                                            logic [3:0] c, logic f, logic l);
    ptw16_pkg::result_t r;
    r.kind       = k;
    r.mem_addr   = a;
    r.write_data = w;
    r.phys_addr  = p;
    r.fault_code = c;
    r.flush_tlb  = f;
    r.last       = l;
    return r;
  endfunction

  // request-side field checks
  always_comb begin
    sel_hi    = va[63];
    tsz       = sel_hi ? cfg.tcr[21:16] : cfg.tcr[5:0];
    gran      = sel_hi ? cfg.tcr[31:30] : cfg.tcr[15:14];
    base      = sel_hi ? cfg.high_base : cfg.low_base;
    top_mask  = ~({64{1'b1}} >> tsz);
    top_ok    = sel_hi ? ((va & top_mask) == top_mask) : ((va & top_mask) == 64'd0);
    tsz_ok    = (tsz >= ptw16_pkg::TSZ_MIN) && (tsz <= ptw16_pkg::TSZ_MAX);
    idx_shift = 4'(tsz - ptw16_pkg::TSZ_MIN);
    l1_idx    = va[46:36] & (11'h7FF >> idx_shift);
    l1_addr   = {1'b0, base} + {27'd0, l1_idx, 3'b000};
  end

  // entry-side fields
  always_comb begin
    nxt_idx  = (phase_r == PH_L1) ? saved_low_r[35:25] : saved_low_r[24:14];
    nxt_addr = {1'b0, rdata[39:14], nxt_idx, 3'b000};
    wdata    = rdata & ~(64'h3 << ptw16_pkg::AP_POS) & ~(64'h3 << ptw16_pkg::XN_POS);
    wdata    = wdata | (64'h2 << ptw16_pkg::XN_POS);
    pa       = {rdata[39:14], saved_low_r[13:0]};
    case (phase_r)
      PH_L1:   begin code_zero = ptw16_pkg::FLT_L1_ZERO; code_type = ptw16_pkg::FLT_L1_TYPE; end
      PH_L2:   begin code_zero = ptw16_pkg::FLT_L2_ZERO; code_type = ptw16_pkg::FLT_L2_TYPE; end
      default: begin code_zero = ptw16_pkg::FLT_L3_ZERO; code_type = ptw16_pkg::FLT_L3_TYPE; end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    saved_low_nxt  = saved_low_r;
    exec_nxt       = exec_r;
    final_addr_nxt = final_addr_r;
    push.cnt = 2'd0;
    push.r0  = mk(ptw16_pkg::KIND_READ, '0, '0, '0, ptw16_pkg::FLT_NONE, 1'b0, 1'b1);
    push.r1  = push.r0;
    if (proc) begin
      if (!cmd) begin
        phase_nxt = PH_IDLE;
        push.cnt  = 2'd1;
        if (cfg.tcr[34:32] != ptw16_pkg::IPS_40) begin
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, ptw16_pkg::FLT_IPS, 1'b0, 1'b1);
        end else if (!top_ok) begin
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, ptw16_pkg::FLT_UPPER, 1'b0, 1'b1);
        end else if (gran != ptw16_pkg::GRAN_16K) begin
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, ptw16_pkg::FLT_GRANULE, 1'b0, 1'b1);
        end else if (!tsz_ok) begin
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, ptw16_pkg::FLT_SIZE, 1'b0, 1'b1);
        end else begin
          saved_low_nxt = va[35:0];
          exec_nxt      = make_exec;
          phase_nxt     = PH_L1;
          push.r0 = mk(ptw16_pkg::KIND_READ, l1_addr, '0, '0, ptw16_pkg::FLT_NONE, 1'b0, 1'b1);
        end
      end else if (phase_r != PH_IDLE) begin
        push.cnt = 2'd1;
        if (rdata == 64'd0) begin
          phase_nxt = PH_IDLE;
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, code_zero, 1'b0, 1'b1);
        end else if (rdata[1:0] != ptw16_pkg::TYPE_TABLE) begin
          phase_nxt = PH_IDLE;
          push.r0 = mk(ptw16_pkg::KIND_FAULT, '0, '0, '0, code_type, 1'b0, 1'b1);
        end else begin
          unique case (phase_r)
            PH_L1: begin
              phase_nxt = PH_L2;
              push.r0 = mk(ptw16_pkg::KIND_READ, nxt_addr, '0, '0, ptw16_pkg::FLT_NONE,
                           1'b0, 1'b1);
            end
            PH_L2: begin
              phase_nxt      = PH_L3;
              final_addr_nxt = nxt_addr;
              push.r0 = mk(ptw16_pkg::KIND_READ, nxt_addr, '0, '0, ptw16_pkg::FLT_NONE,
                           1'b0, 1'b1);
            end
            default: begin
              // level 3: optional write-back, then the translation
              phase_nxt = PH_IDLE;
              if (exec_r) begin
                push.cnt = 2'd2;
                push.r0 = mk(ptw16_pkg::KIND_WRITE, final_addr_r, wdata, '0,
                             ptw16_pkg::FLT_NONE, 1'b0, 1'b0);
                push.r1 = mk(ptw16_pkg::KIND_DONE, '0, '0, pa, ptw16_pkg::FLT_NONE,
                             1'b1, 1'b1);
              end else begin
                push.r0 = mk(ptw16_pkg::KIND_DONE, '0, '0, pa, ptw16_pkg::FLT_NONE,
                             1'b0, 1'b1);
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      saved_low_r  <= '0;
      exec_r       <= 1'b0;
      final_addr_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      saved_low_r  <= saved_low_nxt;
      exec_r       <= exec_nxt;
      final_addr_r <= final_addr_nxt;
    end
  end

endmodule

// ----- hdl/ptw16_outq.sv -----
module ptw16_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  ptw16_pkg::push_t    push,
  input  logic                out_stall,
  output logic                room,
  output logic                out_valid,
  output ptw16_pkg::result_t  head
);

  ptw16_pkg::result_t ent_r [4];
  logic [2:0] count_r;
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [1:0] wr_ptr_p1;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= 3'd2);  // space for a two-result item
  assign head      = ent_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_r + {1'b0, push.cnt} - {2'b00, pop};
      wr_ptr_r <= wr_ptr_r + push.cnt;
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// ----- hdl/ptw16_checker.sv -----
module ptw16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_fault_code,
  input logic        out_flush_tlb,
  input logic        out_last
);

  // nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  // a write-back is never last and is followed at once by a flushing done
  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == ptw16_pkg::KIND_WRITE) && !out_last
    |=> out_valid && (out_kind == ptw16_pkg::KIND_DONE) && out_flush_tlb)
    else $error("write-back not followed by done");

  // faults carry a code and end their item
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == ptw16_pkg::KIND_FAULT)
    |-> (out_fault_code != ptw16_pkg::FLT_NONE) && out_last && !out_flush_tlb)
    else $error("bad fault result");

endmodule

bind page_table_walker_16k ptw16_checker u_ptw16_checker (.*);

// ----- tb/sv/ptw16_tb_pkg.sv -----
`timescale 1ns / 1ps
package ptw16_tb_pkg;
  import ptw16_pkg::*;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_ENTRY     = 1'b1;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_L1,
    WALK_L2,
    WALK_L3
  } walk_level_e;

  // Shadow copy of the walker: config, walk state and the results still owed.
  class walker_shadow;
    logic [63:0]          tcr;
    logic [PHYS_BITS-1:0] low_base;
    logic [PHYS_BITS-1:0] high_base;
    walk_level_e          level;
    logic [35:0]          saved_va;
    logic                 exec_flag;
    logic [ADDR_BITS-1:0] leaf_addr;
    result_t              due_results[$];
    int unsigned          errors;
    int unsigned          translations;
    int unsigned          rewrites;
    int unsigned          faults;
    int unsigned          strays;
    logic [15:0]          fault_codes_seen;

    function new();
      tcr              = '0;
      low_base         = '0;
      high_base        = '0;
      level            = WALK_IDLE;
      saved_va         = '0;
      exec_flag        = 1'b0;
      leaf_addr        = '0;
      errors           = 0;
      translations     = 0;
      rewrites         = 0;
      faults           = 0;
      strays           = 0;
      fault_codes_seen = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_TCR:       tcr = data;
        CFG_LOW_BASE:  low_base = data[PHYS_BITS-1:0];
        CFG_HIGH_BASE: high_base = data[PHYS_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void emit(kind_t kind, logic [ADDR_BITS-1:0] addr, logic [63:0] wdata,
                       logic [PHYS_BITS-1:0] pa, logic [3:0] code, logic flush, logic last);
      result_t r;
      r.kind       = kind;
      r.mem_addr   = addr;
      r.write_data = wdata;
      r.phys_addr  = pa;
      r.fault_code = code;
      r.flush_tlb  = flush;
      r.last       = last;
      due_results.push_back(r);
    endfunction

    function int fail_walk(logic [3:0] code);
      level = WALK_IDLE;
      faults++;
      fault_codes_seen[code] = 1'b1;
      emit(KIND_FAULT, '0, '0, '0, code, 1'b0, 1'b1);
      return 1;
    endfunction

    // next table address: entry's output address field plus eight per index
    function logic [ADDR_BITS-1:0] next_table(logic [63:0] te, logic [10:0] idx);
      return {1'b0, te[PHYS_BITS-1:GRAN_BITS], {GRAN_BITS{1'b0}}} + {27'b0, idx, 3'b000};
    endfunction

    // Takes one accepted item, queues the results it causes, returns their count.
    function int accept_item(logic cmd, logic [63:0] va, logic mx, logic [63:0] te);
      logic [5:0]           tsz;
      logic [1:0]           gran;
      logic [PHYS_BITS-1:0] base;
      logic [63:0]          top_want;
      logic [63:0]          idx_bits;
      int                   nres;
      if (cmd == CMD_TRANSLATE) begin
        level = WALK_IDLE;
        if (tcr[34:32] != IPS_40) return fail_walk(FLT_IPS);
        if (va[63]) begin
          tsz      = tcr[21:16];
          gran     = tcr[31:30];
          base     = high_base;
          top_want = (64'd1 << tsz) - 64'd1;
        end else begin
          tsz      = tcr[5:0];
          gran     = tcr[15:14];
          base     = low_base;
          top_want = '0;
        end
        // a zero size field leaves nothing to check above the region
        if (tsz != 0 && (va >> (64 - tsz)) != top_want) return fail_walk(FLT_UPPER);
        if (gran != GRAN_16K) return fail_walk(FLT_GRANULE);
        if (tsz < TSZ_MIN || tsz > TSZ_MAX) return fail_walk(FLT_SIZE);
        idx_bits  = (va >> 36) & ((64'd1 << (28 - tsz)) - 64'd1);
        saved_va  = va[35:0];
        exec_flag = mx;
        level     = WALK_L1;
        emit(KIND_READ, {1'b0, base} + {27'b0, idx_bits[10:0], 3'b000}, '0, '0,
             FLT_NONE, 1'b0, 1'b1);
        return 1;
      end
      if (level == WALK_IDLE) begin
        strays++;
        return 0;
      end
      if (te == '0)
        return fail_walk(level == WALK_L1 ? FLT_L1_ZERO :
                         level == WALK_L2 ? FLT_L2_ZERO : FLT_L3_ZERO);
      if (te[1:0] != TYPE_TABLE)
        return fail_walk(level == WALK_L1 ? FLT_L1_TYPE :
                         level == WALK_L2 ? FLT_L2_TYPE : FLT_L3_TYPE);
      if (level == WALK_L1) begin
        level = WALK_L2;
        emit(KIND_READ, next_table(te, saved_va[35:25]), '0, '0, FLT_NONE, 1'b0, 1'b1);
        return 1;
      end
      if (level == WALK_L2) begin
        level     = WALK_L3;
        leaf_addr = next_table(te, saved_va[24:14]);
        emit(KIND_READ, leaf_addr, '0, '0, FLT_NONE, 1'b0, 1'b1);
        return 1;
      end
      level = WALK_IDLE;
      nres  = 0;
      if (exec_flag) begin
        // kernel read-write, executable at EL1 only
        te[AP_POS +: 2] = 2'b00;
        te[XN_POS +: 2] = 2'b10;
        emit(KIND_WRITE, leaf_addr, te, '0, FLT_NONE, 1'b0, 1'b0);
        rewrites++;
        nres = 1;
      end
      emit(KIND_DONE, '0, '0, {te[PHYS_BITS-1:GRAN_BITS], saved_va[GRAN_BITS-1:0]},
           FLT_NONE, exec_flag, 1'b1);
      translations++;
      return nres + 1;
    endfunction

    function bit field_bad(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none, actual kind %0d addr %h",
                 $time, got.kind, got.mem_addr);
        return;
      end
      want = due_results.pop_front();
      bad  = 1'b0;
      bad |= field_bad("kind", want.kind, got.kind);
      bad |= field_bad("mem_addr", want.mem_addr, got.mem_addr);
      bad |= field_bad("write_data", want.write_data, got.write_data);
      bad |= field_bad("phys_addr", want.phys_addr, got.phys_addr);
      bad |= field_bad("fault_code", want.fault_code, got.fault_code);
      bad |= field_bad("flush_tlb", want.flush_tlb, got.flush_tlb);
      bad |= field_bad("last", want.last, got.last);
      if (bad) errors++;
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Top level for the 16 KB granule table walker.
// Items go in through a bursty sender; results are taken by a receiver that
// stalls in changing patterns. Every accepted item is also fed to the shadow
// walker, which owes a list of results; each result that comes out is
// matched against the oldest one owed.
module tb_top;
  import ptw16_pkg::*;
  import ptw16_tb_pkg::*;

  localparam int MAX_CYCLES    = 400000; // far beyond the slowest legal run
  localparam int SETTLE_CYCLES = 8;      // input register and result queue plus slack
  localparam int NUM_SETTINGS  = 10;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_cmd         = CMD_TRANSLATE;
  logic [63:0] in_virt_addr   = '0;
  logic        in_make_exec   = 1'b0;
  logic [63:0] in_read_data   = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_kind;
  logic [40:0] out_mem_addr;
  logic [63:0] out_write_data;
  logic [39:0] out_phys_addr;
  logic [3:0]  out_fault_code;
  logic        out_flush_tlb;
  logic        out_last;
  logic        cfg_we         = 1'b0;
  logic [1:0]  cfg_index      = CFG_TCR;
  logic [63:0] cfg_data       = '0;

  walker_shadow shadow = new();
  int unsigned  cycle_count = 0;
  int unsigned  items_sent  = 0;
  int           burst_left  = 0;
  stall_mode_e  stall_mode  = STALL_NONE;
  int           stall_span  = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  page_table_walker_16k u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_virt_addr   (in_virt_addr),
    .in_make_exec   (in_make_exec),
    .in_read_data   (in_read_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_mem_addr   (out_mem_addr),
    .out_write_data (out_write_data),
    .out_phys_addr  (out_phys_addr),
    .out_fault_code (out_fault_code),
    .out_flush_tlb  (out_flush_tlb),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("%0t: run exceeded %0d cycles, %0d results still owed",
               $time, MAX_CYCLES, shadow.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall: switches between free running, light random, a fixed
  // rhythm and heavy random stalling, each held for a random span.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span = stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= ((cycle_count % 9) < 4);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result side: sample at the edge where the result is taken.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind       = kind_t'(out_kind);
      got.mem_addr   = out_mem_addr;
      got.write_data = out_write_data;
      got.phys_addr  = out_phys_addr;
      got.fault_code = out_fault_code;
      got.flush_tlb  = out_flush_tlb;
      got.last       = out_last;
      shadow.check_result(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PHYS_BITS-1:0] rand_base();
    logic [63:0] v;
    v = rand64();
    return v[PHYS_BITS-1:0];
  endfunction

  // Random control word with the walker's fields forced; other bits are noise.
  function automatic logic [63:0] build_tcr(logic [5:0] lo_tsz, logic [5:0] hi_tsz,
                                            logic [1:0] lo_gran, logic [1:0] hi_gran,
                                            logic [2:0] ips);
    logic [63:0] tcr;
    tcr        = rand64();
    tcr[5:0]   = lo_tsz;
    tcr[15:14] = lo_gran;
    tcr[21:16] = hi_tsz;
    tcr[31:30] = hi_gran;
    tcr[34:32] = ips;
    return tcr;
  endfunction

  function automatic logic [5:0] pick_tsz();
    return ($urandom_range(0, 4) != 0) ? 6'($urandom_range(17, 27)) : 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [1:0] pick_gran();
    return ($urandom_range(0, 6) != 0) ? GRAN_16K : 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [2:0] pick_ips();
    return ($urandom_range(0, 9) != 0) ? IPS_40 : 3'($urandom_range(0, 7));
  endfunction

  // Address that passes the upper-bit check for the current size field;
  // now and then all index bits at one extreme.
  function automatic logic [63:0] good_va(logic side);
    logic [63:0] va;
    logic [63:0] keep;
    logic [5:0]  tsz;
    case ($urandom_range(0, 7))
      0:       va = '1;
      1:       va = '0;
      default: va = rand64();
    endcase
    tsz = side ? shadow.tcr[21:16] : shadow.tcr[5:0];
    if (tsz != 0) begin
      keep = (64'd1 << (64 - tsz)) - 64'd1;
      va   = side ? (va | ~keep) : (va & keep);
    end
    va[63] = side;
    return va;
  endfunction

  function automatic logic [63:0] table_entry();
    logic [63:0] te;
    case ($urandom_range(0, 7))
      0:       te = '1;
      1:       te = '0;
      default: te = rand64();
    endcase
    te[1:0] = TYPE_TABLE;
    return te;
  endfunction

  // zero word or a non-table type
  function automatic logic [63:0] broken_entry();
    logic [63:0] te;
    if ($urandom_range(0, 1) != 0) return '0;
    te      = rand64();
    te[1:0] = 2'($urandom_range(0, 2));
    if (te == '0) te[2] = 1'b1;
    return te;
  endfunction

  // Drives one item and holds it until taken. The sender runs in bursts;
  // a new burst may start after a gap with valid low.
  task automatic send_item(input logic cmd, input logic [63:0] va, input logic mx,
                           input logic [63:0] rd, output int nres);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_virt_addr <= va;
    in_make_exec <= mx;
    in_read_data <= rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nres = shadow.accept_item(cmd, va, mx, rd);
    items_sent++;
  endtask

  task automatic send_request(input logic [63:0] va, input logic mx);
    int nres;
    send_item(CMD_TRANSLATE, va, mx, rand64(), nres);
  endtask

  task automatic send_entry(input logic [63:0] te);
    int nres;
    send_item(CMD_ENTRY, rand64(), ($urandom_range(0, 1) != 0), te, nres);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow.write_reg(idx, data);
  endtask

  // All three registers, back to back; base writes carry junk above bit 39.
  task automatic set_config(input logic [63:0] tcr, input logic [PHYS_BITS-1:0] lo,
                            input logic [PHYS_BITS-1:0] hi);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_TCR, tcr);
    write_reg(CFG_LOW_BASE, {junk[23:0], lo});
    write_reg(CFG_HIGH_BASE, {junk[31:8], hi});
    cfg_we <= 1'b0;
  endtask

  // Wait until nothing is owed, then let the pipeline empty of dropped words.
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly complete walks with random contents; the rest is random requests,
  // requests with damaged upper bits and loose entry words. Words that the
  // walker drops do not count towards the target.
  task automatic run_items(input int target);
    int          counted;
    int          pick;
    int          step;
    int          nres;
    logic        side;
    logic        open_walk;
    logic [63:0] va;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      side = ($urandom_range(0, 1) != 0);
      if (pick < 65) begin
        send_item(CMD_TRANSLATE, good_va(side), ($urandom_range(0, 1) != 0), rand64(), nres);
        counted  += (nres != 0);
        open_walk = (shadow.level != WALK_IDLE);
        for (step = 0; step < 3 && open_walk; step++) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            open_walk = 1'b0; // left open; the next request abandons it
          end else begin
            send_item(CMD_ENTRY, rand64(), ($urandom_range(0, 1) != 0),
                      pick < 12 ? broken_entry() : table_entry(), nres);
            counted  += (nres != 0);
            open_walk = (shadow.level != WALK_IDLE);
          end
        end
      end else if (pick < 78) begin
        send_item(CMD_TRANSLATE, rand64(), ($urandom_range(0, 1) != 0), rand64(), nres);
        counted += (nres != 0);
      end else if (pick < 88) begin
        va = good_va(side);
        va[$urandom_range(40, 62)] ^= 1'b1;
        send_item(CMD_TRANSLATE, va, ($urandom_range(0, 1) != 0), rand64(), nres);
        counted += (nres != 0);
      end else begin
        send_item(CMD_ENTRY, rand64(), ($urandom_range(0, 1) != 0),
                  ($urandom_range(0, 3) == 0) ? 64'h0 : rand64(), nres);
        counted += (nres != 0);
      end
    end
  endtask

  initial begin
    logic [63:0]          tcr_next;
    logic [PHYS_BITS-1:0] low_next;
    logic [PHYS_BITS-1:0] high_next;
    int                   n_items;
    int                   setting;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: smallest low size, largest high size, valid granules.
    set_config(build_tcr(TSZ_MIN, TSZ_MAX, GRAN_16K, GRAN_16K, IPS_40), rand_base(),
               rand_base());
    send_entry(table_entry());                 // word with no walk open: dropped
    send_request(64'h0000_7FFF_FFFF_FFFF, 1'b0); // top indices of the low range
    repeat (3) send_entry('1);                  // every entry bit set
    send_request('1, 1'b1);                     // high range, rewrite of the leaf
    repeat (3) send_entry('1);
    send_request(64'h0000_8000_0000_0000, 1'b0); // bit just above the region
    send_request(good_va(1'b0), 1'b0);          // level 1 zero
    send_entry('0);
    send_request(good_va(1'b1), 1'b1);          // level 1 wrong type
    send_entry(64'h0000_00AB_CDEF_4002);
    send_request(good_va(1'b0), 1'b1);          // level 2 zero
    send_entry(table_entry());
    send_entry('0);
    send_request(good_va(1'b1), 1'b0);          // walk abandoned by a new request,
    send_entry(table_entry());
    send_request(good_va(1'b0), 1'b0);          // which then fails at level 2 type
    send_entry(table_entry());
    send_entry(64'h8000_0000_0000_0001);
    send_request(good_va(1'b1), 1'b1);          // level 3 zero
    send_entry(table_entry());
    send_entry(table_entry());
    send_entry('0);
    settle();

    // Random part over a series of settings, extremes first.
    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      case (setting)
        0: begin
          tcr_next  = '0;
          low_next  = '0;
          high_next = '0;
          n_items   = 20;
        end
        1: begin
          tcr_next  = '1;
          low_next  = '1;
          high_next = '1;
          n_items   = 20;
        end
        2: begin
          // top bases: entry addresses carry into bit 40
          tcr_next  = build_tcr(TSZ_MIN, TSZ_MAX, GRAN_16K, GRAN_16K, IPS_40);
          low_next  = '1;
          high_next = '1;
          n_items   = 80;
        end
        3: begin
          tcr_next  = build_tcr(TSZ_MAX, TSZ_MIN, GRAN_16K, GRAN_16K, IPS_40);
          low_next  = '0;
          high_next = '0;
          n_items   = 80;
        end
        4: begin
          // zero size field: empty upper check, then a size fault
          tcr_next  = build_tcr(6'd0, 6'd63, GRAN_16K, GRAN_16K, IPS_40);
          low_next  = rand_base();
          high_next = rand_base();
          n_items   = 30;
        end
        5: begin
          tcr_next  = build_tcr(TSZ_MIN - 6'd1, TSZ_MAX + 6'd1, pick_gran(), pick_gran(),
                                IPS_40);
          low_next  = rand_base();
          high_next = rand_base();
          n_items   = 30;
        end
        default: begin
          tcr_next  = build_tcr(pick_tsz(), pick_tsz(), pick_gran(), pick_gran(), pick_ips());
          low_next  = rand_base();
          high_next = rand_base();
          n_items   = 80;
        end
      endcase
      set_config(tcr_next, low_next, high_next);
      run_items(n_items);
      settle();
    end

    $display("Run covered %0d items: %0d translations (%0d with leaf rewrite), %0d faults",
             items_sent, shadow.translations, shadow.rewrites, shadow.faults);
    $display("Fault codes hit (bit per code) %b, %0d loose entry words, %0d settings",
             shadow.fault_codes_seen, shadow.strays, NUM_SETTINGS + 1);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
